### rtl/rdf_pkg.sv
// Shared types and constants for the radix digit formatter.
// No dependencies; every other rtl file but rdf_ram imports this package.
package rdf_pkg;

  localparam int DEF_VALUE_BITS = 64;
  localparam int IN_W           = 64;
  localparam int STEP_BITS      = 8;
  localparam int CHAR_W         = 8;
  localparam int NUM_CHARS      = 16;
  localparam int DIGIT_W        = 4;
  localparam int RADIX_W        = 5;
  localparam int TOTAL_W        = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int MIN_RADIX      = 2;
  localparam int MAX_RADIX      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture new value, clear tally
    logic div_step;  // run one chunk of the long division
    logic fetch;     // read most significant stored digit
    logic emit;      // load output register, read next digit
    logic bad;       // load the invalid-alphabet result
  } rdf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic chunk_last;  // this division step finishes a digit
    logic quot_zero;   // quotient after this step is zero
    logic ptr_zero;    // digit being emitted is the last one
    logic slot_free;   // output register can take a result
  } rdf_sts_t;

endpackage

### rtl/rdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rdf_alphabet.sv
// Alphabet configuration registers, validity check and digit-to-character lookup.
// Depends on rdf_pkg.
module rdf_alphabet
  import rdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [DIGIT_W-1:0]    digit,
  output logic [CHAR_W-1:0]     digit_char,
  output logic [RADIX_W-1:0]    radix,
  output logic                  alph_ok
);

  logic [RADIX_W-1:0]          len_r;
  logic [CFG_DATA_W-1:0]       low_r;
  logic [CFG_DATA_W-1:0]       high_r;
  logic [NUM_CHARS*CHAR_W-1:0] chars;
  logic                        dup;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHABET_LENGTH: len_r  <= cfg_data[RADIX_W-1:0];
        CFG_ALPHABET_LOW:    low_r  <= cfg_data;
        CFG_ALPHABET_HIGH:   high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chars = {high_r, low_r};

  // Compare every pair inside the active alphabet
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      for (int j = i + 1; j < NUM_CHARS; j++) begin
        if ((RADIX_W'(j) < len_r) && (chars[i*CHAR_W +: CHAR_W] == chars[j*CHAR_W +: CHAR_W]))
          dup = 1'b1;
      end
    end
  end

  assign alph_ok    = (len_r >= RADIX_W'(MIN_RADIX)) && (len_r <= RADIX_W'(MAX_RADIX)) && !dup;
  assign radix      = len_r;
  assign digit_char = chars[{digit, 3'b000} +: CHAR_W];

endmodule

### rtl/rdf_datapath.sv
// Datapath: chunked long division by the radix, digit store, output register.
// Depends on rdf_pkg and rdf_ram.
module rdf_datapath
  import rdf_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdf_cmd_t           cmd,
  output rdf_sts_t           sts,
  input  logic [IN_W-1:0]    in_number_value,
  input  logic [RADIX_W-1:0] radix,
  output logic [DIGIT_W-1:0] ram_digit,
  input  logic [CHAR_W-1:0]  digit_char,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_alphabet_ok,
  output logic               out_run_last,
  output logic [TOTAL_W-1:0] out_char_total
);

  localparam int NCHUNK   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = NCHUNK * STEP_BITS;
  localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int ADDR_W   = $clog2(VALUE_BITS);
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);

  logic [PAD_BITS-1:0]  div_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [CHUNK_W-1:0]   chunk_r;
  logic [CNT_W-1:0]     tally_r;
  logic [ADDR_W-1:0]    ptr_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_ok_r;
  logic                 out_last_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic [STEP_BITS-1:0] q_bits;
  logic [DIGIT_W-1:0]   rem_step;
  logic [RADIX_W-1:0]   trial;
  logic                 ge;
  logic [PAD_BITS-1:0]  div_nxt;
  logic                 digit_end;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;

  // One restoring step per dividend bit, STEP_BITS bits per cycle
  always_comb begin
    rem_step = rem_r;
    q_bits   = '0;
    trial    = '0;
    ge       = 1'b0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_step, div_r[PAD_BITS-1-i]};
      ge    = (trial >= radix);
      q_bits[STEP_BITS-1-i] = ge;
      rem_step = ge ? DIGIT_W'(trial - radix) : DIGIT_W'(trial);
    end
  end

  assign div_nxt   = (div_r << STEP_BITS) | PAD_BITS'(q_bits);
  assign digit_end = cmd.div_step && (chunk_r == CHUNK_W'(NCHUNK - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= '0;
      rem_r   <= '0;
      chunk_r <= '0;
      tally_r <= '0;
      ptr_r   <= '0;
    end else begin
      if (cmd.load) begin
        div_r   <= PAD_BITS'(in_number_value[VALUE_BITS-1:0]);
        rem_r   <= '0;
        chunk_r <= '0;
        tally_r <= '0;
      end else if (cmd.div_step) begin
        div_r <= div_nxt;
        if (digit_end) begin
          rem_r   <= '0;
          chunk_r <= '0;
          tally_r <= tally_r + 1'b1;
        end else begin
          rem_r   <= rem_step;
          chunk_r <= chunk_r + 1'b1;
        end
      end
      if (cmd.fetch) begin
        ptr_r <= ADDR_W'(tally_r - 1'b1);
      end else if (cmd.emit && (ptr_r != '0)) begin
        ptr_r <= ptr_r - 1'b1;
      end
    end
  end

  assign rd_en   = cmd.fetch || (cmd.emit && (ptr_r != '0));
  assign rd_addr = cmd.fetch ? ADDR_W'(tally_r - 1'b1) : ADDR_W'(ptr_r - 1'b1);

  rdf_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (digit_end),
    .wr_addr (tally_r[ADDR_W-1:0]),
    .wr_data (rem_step),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_digit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.bad) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r  <= digit_char;
      out_ok_r    <= 1'b1;
      out_last_r  <= (ptr_r == '0);
      out_total_r <= (ptr_r == '0) ? TOTAL_W'(tally_r) : '0;
    end else if (cmd.bad) begin
      out_char_r  <= '0;
      out_ok_r    <= 1'b0;
      out_last_r  <= 1'b1;
      out_total_r <= '0;
    end
  end

  assign sts.chunk_last = (chunk_r == CHUNK_W'(NCHUNK - 1));
  assign sts.quot_zero  = (div_nxt == '0);
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.slot_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_alphabet_ok = out_ok_r;
  assign out_run_last    = out_last_r;
  assign out_char_total  = out_total_r;

endmodule

### rtl/rdf_ctrl.sv
// Controller state machine: sequences division, digit readout and result loading.
// Depends on rdf_pkg.
module rdf_ctrl
  import rdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     alph_ok,
  input  rdf_sts_t sts,
  output rdf_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_FETCH = 6'b001000,
    S_EMIT  = 6'b010000,
    S_BAD   = 6'b100000
  } rdf_state_t;

  rdf_state_t state_r;
  rdf_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = alph_ok ? S_DIV : S_BAD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.chunk_last && sts.quot_zero)
          state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.ptr_zero)
            state_nxt = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts.slot_free) begin
          cmd.bad   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/radix_digit_formatter.sv
// Radix digit formatter top level: converts an unsigned value to alphabet digits.
// Depends on rdf_pkg, rdf_alphabet, rdf_ctrl, rdf_datapath (which holds rdf_ram).
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    in_number_value
//   out_     result     out_valid / out_ready  out_char, out_alphabet_ok,
//                                              out_run_last, out_char_total
//   cfg_     write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Division: each digit takes one full pass of the long division over the value
// (8 dividend bits per cycle through the shared long-division step), then the
// digits are emitted one per cycle while the output register can take them.
// An invalid alphabet gives one result.
// Reset: synchronous, active low; clears the alphabet to length 0 and the FSM to idle.
// Stalls: out_ready low holds the output register and the digit readout; a new
// request is taken while the last result of the previous one still waits.
module radix_digit_formatter
  import rdf_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_W-1:0]       in_number_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_alphabet_ok,
  output logic                  out_run_last,
  output logic [TOTAL_W-1:0]    out_char_total,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rdf_cmd_t           cmd;
  rdf_sts_t           sts;
  logic [DIGIT_W-1:0] ram_digit;
  logic [CHAR_W-1:0]  digit_char;
  logic [RADIX_W-1:0] radix;
  logic               alph_ok;

  // Alphabet registers, duplicate check and character lookup
  rdf_alphabet u_alphabet (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .digit      (ram_digit),
    .digit_char (digit_char),
    .radix      (radix),
    .alph_ok    (alph_ok)
  );

  // Sequencer: check, divide, fetch, emit, or report an invalid alphabet
  rdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .alph_ok  (alph_ok),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Division engine, digit store and output register
  rdf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_number_value (in_number_value),
    .radix           (radix),
    .ram_digit       (ram_digit),
    .digit_char      (digit_char),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_alphabet_ok (out_alphabet_ok),
    .out_run_last    (out_run_last),
    .out_char_total  (out_char_total)
  );

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.bad) |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // A taken request makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // The invalid-alphabet result is a lone, empty, final result
  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_alphabet_ok) |-> (out_run_last && (out_char_total == '0)
      && (out_char == '0)))
    else $error("malformed invalid-alphabet result");

  // Count only on the final digit, and never above the digit store depth
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alphabet_ok) |-> (out_run_last ? ((out_char_total != '0)
      && (out_char_total <= TOTAL_W'(VALUE_BITS))) : (out_char_total == '0)))
    else $error("character count out of place");

endmodule

### test/tb_radix_digit_formatter.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_formatter: drives values, mirrors the alphabet
// registers and predicts every digit result. Depends on rdf_pkg and the formatter RTL.
module tb_radix_digit_formatter;
  import rdf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000; // limit on the whole run
  localparam int          SETTLE_CYCLES = 16;        // margin after the last result
  localparam int          SEGMENTS = 20;
  localparam int          SEG_ITEMS = 21;
  localparam int          MAX_DIGITS = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3; // no register behind this index

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               ok;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } digit_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_W-1:0]       in_number_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_alphabet_ok;
  logic                  out_run_last;
  logic [TOTAL_W-1:0]    out_char_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the alphabet registers, updated when a write is accepted.
  logic [RADIX_W-1:0]    alpha_len = '0;
  logic [63:0]           alpha_low = '0;
  logic [63:0]           alpha_high = '0;

  logic [IN_W-1:0]       pending_values[$];   // requests not yet presented
  digit_result_t         expected_digits[$];  // results predicted, oldest first
  logic                  in_taken = 1'b0;     // request accepted at the last rising edge
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    mismatch_count = 0;
  int unsigned           cycle_count = 0;

  radix_digit_formatter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number_value (in_number_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_alphabet_ok (out_alphabet_ok),
    .out_run_last    (out_run_last),
    .out_char_total  (out_char_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Character for digit d: low register holds digits 0..7, high register 8..15.
  function automatic logic [CHAR_W-1:0] glyph(input int d);
    logic [127:0] all_chars;
    all_chars = {alpha_high, alpha_low};
    return all_chars[d*8 +: 8];
  endfunction

  // Usable only with a length from MIN_RADIX to MAX_RADIX and no repeated
  // character among the first alpha_len entries; bytes past the length do not count.
  function automatic bit alphabet_usable();
    if (alpha_len < MIN_RADIX || alpha_len > MAX_RADIX) return 1'b0;
    for (int i = 0; i < alpha_len; i++)
      for (int j = i + 1; j < alpha_len; j++)
        if (glyph(i) == glyph(j)) return 1'b0;
    return 1'b1;
  endfunction

  // Expand one request into its digit results, most significant first.
  function automatic void predict_digits(input logic [IN_W-1:0] value);
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    logic [IN_W-1:0]    rest;
    logic [IN_W-1:0]    base;
    int                 count;
    digit_result_t      r;
    if (!alphabet_usable()) begin
      // bad alphabet: a single flagged result with no character and zero count
      r.ch = '0;
      r.ok = 1'b0;
      r.last = 1'b1;
      r.total = '0;
      expected_digits.push_back(r);
      return;
    end
    base = IN_W'(alpha_len);
    rest = value;
    count = 0;
    do begin
      digits[count] = DIGIT_W'(rest % base);
      rest = rest / base;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      r.ch = glyph(digits[k]);
      r.ok = 1'b1;
      r.last = (k == 0);
      r.total = (k == 0) ? TOTAL_W'(count) : '0;
      expected_digits.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present a new request once the previous one is taken, hold otherwise.
  // Inputs change at the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_number_value <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result,
  // and enforce the cycle limit.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digit_result_t exp_r;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) predict_digits(in_number_value);
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected result char=%h ok=%b last=%b total=%0d", $time,
                   out_char, out_alphabet_ok, out_run_last, out_char_total);
          mismatch_count++;
        end else begin
          exp_r = expected_digits.pop_front();
          if (out_char !== exp_r.ch) begin
            $display("%0t: char expected %h actual %h", $time, exp_r.ch, out_char);
            mismatch_count++;
          end
          if (out_alphabet_ok !== exp_r.ok) begin
            $display("%0t: alphabet_ok expected %b actual %b", $time, exp_r.ok,
                     out_alphabet_ok);
            mismatch_count++;
          end
          if (out_run_last !== exp_r.last) begin
            $display("%0t: run_last expected %b actual %b", $time, exp_r.last,
                     out_run_last);
            mismatch_count++;
          end
          if (out_char_total !== exp_r.total) begin
            $display("%0t: char_total expected %0d actual %0d", $time, exp_r.total,
                     out_char_total);
            mismatch_count++;
          end
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_digits.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register; update the mirror at the edge where the write lands.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALPHABET_LENGTH: alpha_len = data[RADIX_W-1:0];
      CFG_ALPHABET_LOW:    alpha_low = data;
      CFG_ALPHABET_HIGH:   alpha_high = data;
      default:             ; // unmapped index: the write is dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Length goes in the low bits; random upper bits must be ignored by the block.
  task automatic set_alphabet(input int len, input logic [127:0] chars);
    write_reg(CFG_ALPHABET_LOW, chars[63:0]);
    write_reg(CFG_ALPHABET_HIGH, chars[127:64]);
    write_reg(CFG_ALPHABET_LENGTH,
              {(CFG_DATA_W-RADIX_W)'({$urandom, $urandom}), RADIX_W'(len)});
  endtask

  // Hold off the sender until every request is taken and every result is in,
  // then let the block settle before any register write.
  task automatic drain();
    do @(posedge clk);
    while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sixteen distinct random characters; any byte value, zero included.
  function automatic logic [127:0] distinct_glyphs();
    logic [127:0] g;
    bit           used[256];
    int           b;
    g = '0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      do b = $urandom_range(255); while (used[b]);
      used[b] = 1'b1;
      g[i*8 +: 8] = 8'(b);
    end
    return g;
  endfunction

  // Random value: zero and small values, all ones and top bit set, radix powers
  // and their neighbors, random widths, full-width random.
  function automatic logic [IN_W-1:0] next_value(input int radix);
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] p;
    int              k;
    case ($urandom_range(7))
      0: v = IN_W'($urandom_range(0, 40));
      1: v = $urandom_range(1) ? '1 : ({$urandom, $urandom} | (64'h1 << 63));
      2: begin
        // step over a digit-count boundary: radix^k - 1, radix^k, radix^k + 1
        p = IN_W'(1);
        k = $urandom_range(1, 63);
        repeat (k) if (p <= {IN_W{1'b1}} / IN_W'(radix)) p = p * IN_W'(radix);
        v = p + IN_W'($urandom_range(2)) - IN_W'(1);
      end
      3, 4: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int           len;
    int           pick;
    int           dup_from;
    int           dup_to;
    logic [127:0] chars;
    int           idle_send[4] = '{0, 51, 0, 21};
    int           idle_recv[4] = '{0, 0, 51, 21};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, both sides idling lightly.
    send_idle_pct = 21;
    recv_stall_pct = 21;

    // reset alphabet has length 0: every request yields the invalid result
    pending_values.push_back('0);
    pending_values.push_back('1);
    drain();

    // write to the unmapped index must change nothing
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    pending_values.push_back(64'd5);
    drain();

    // hex, radix 16
    set_alphabet(16, {64'h6665646362613938, 64'h3736353433323130});
    pending_values.push_back('0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd15);
    pending_values.push_back(64'd16);
    pending_values.push_back('1);
    pending_values.push_back(64'h8000_0000_0000_0000);
    drain();

    // binary with a zero byte and 0xff as the two characters; all ones gives 64 digits
    chars = distinct_glyphs();
    chars[15:0] = 16'hff00;
    chars[127:16] = 112'({$urandom, $urandom, $urandom, $urandom});
    set_alphabet(2, chars);
    pending_values.push_back('1);
    pending_values.push_back('0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'h8000_0000_0000_0000);
    drain();

    // decimal with a zero byte for digit 3
    set_alphabet(10, {48'h0, 16'h3938, 64'h3736353400323130});
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd10000000000000000000);
    pending_values.push_back('1);
    drain();

    // repeated character at the very end of a full-length alphabet
    chars = distinct_glyphs();
    chars[127:120] = chars[7:0];
    set_alphabet(16, chars);
    pending_values.push_back(64'd1);
    drain();

    // length out of range on both sides
    set_alphabet(17, distinct_glyphs());
    pending_values.push_back(64'd100);
    drain();
    set_alphabet(1, distinct_glyphs());
    pending_values.push_back(64'd100);
    drain();
    set_alphabet(31, distinct_glyphs());
    pending_values.push_back('1);
    drain();

    // repeats past the length do not count
    chars = distinct_glyphs();
    chars[127:24] = {13{chars[7:0]}};
    set_alphabet(3, chars);
    pending_values.push_back('1);
    drain();

    // Random part: each segment gets a fresh alphabet and one idling pattern.
    // The drain between segments keeps the sender paused until all results arrive.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      chars = distinct_glyphs();
      pick = $urandom_range(9);
      if (seg == 0) len = 2;
      else if (seg == 1) len = 16;
      else if (pick == 0) len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(17, 31);
      else len = $urandom_range(2, 16);
      if (seg > 1 && pick == 1 && len >= 2) begin
        // duplicate one character inside the alphabet
        dup_from = $urandom_range(len - 1);
        dup_to = (dup_from + 1 + $urandom_range(len - 2)) % len;
        chars[dup_to*8 +: 8] = chars[dup_from*8 +: 8];
      end
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
      set_alphabet(len, chars);
      send_idle_pct = idle_send[seg % 4];
      recv_stall_pct = idle_recv[seg % 4];
      for (int n = 0; n < SEG_ITEMS; n++)
        pending_values.push_back(next_value((len >= 2 && len <= 16) ? len : 10));
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
